// ----- src/node_selection_refcount_table_core_assert.svh -----
`ifndef NODE_SELECTION_REFCOUNT_TABLE_CORE_ASSERT_SVH
`define NODE_SELECTION_REFCOUNT_TABLE_CORE_ASSERT_SVH
// clocked check, held off during reset
`define NSRT_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("nsrt check failed");
// clocked check, also live in reset
`define NSRT_CHECK_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("nsrt check failed");
`endif

// ----- src/nsrt_pkg.sv -----
package nsrt_pkg;
  localparam int POINT_SLOTS = 64;
  localparam int PRIM_SLOTS  = 64;
  localparam int SEG_SLOTS   = 32;
  localparam int NODE_BITS   = 32;

  localparam int PT_IW = $clog2(POINT_SLOTS);
  localparam int PR_IW = $clog2(PRIM_SLOTS);
  localparam int SG_IW = $clog2(SEG_SLOTS);

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic [2:0] ST_NEW     = 3'd0;
  localparam logic [2:0] ST_RAISED  = 3'd1;
  localparam logic [2:0] ST_MARKED  = 3'd2;
  localparam logic [2:0] ST_LOWERED = 3'd3;
  localparam logic [2:0] ST_FREED   = 3'd4;
  localparam logic [2:0] ST_NONE    = 3'd5;
  localparam logic [2:0] ST_FULL    = 3'd6;

  localparam logic [2:0] ADDR_ADD_MODE = 3'd0;

  typedef struct packed {
    logic capture;
    logic match;
    logic seek;
    logic exec;
  } nsrt_cmd_t;

  typedef struct packed {
    logic out_busy;
  } nsrt_stat_t;
endpackage

// ----- src/nsrt_ctrl.sv -----
module nsrt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  nsrt_pkg::nsrt_stat_t stat,
  output nsrt_pkg::nsrt_cmd_t  cmd
);
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MATCH = 2'd1;
  localparam logic [1:0] S_SEEK  = 2'd2;
  localparam logic [1:0] S_EXEC  = 2'd3;

  logic [1:0] state, state_next;

  assign in_ready    = (state == S_IDLE);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.match   = (state == S_MATCH);
  assign cmd.seek    = (state == S_SEEK);
  assign cmd.exec    = (state == S_EXEC) && !stat.out_busy;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (cmd.capture) state_next = S_MATCH;
      S_MATCH: state_next = S_SEEK;
      S_SEEK:  state_next = S_EXEC;
      S_EXEC:  if (cmd.exec) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule

// ----- src/nsrt_datapath.sv -----
module nsrt_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  nsrt_pkg::nsrt_cmd_t  cmd,
  output nsrt_pkg::nsrt_stat_t stat,
  input  logic                 add_mode,
  input  logic                 opcode,
  input  logic [15:0]          segment_id,
  input  logic [15:0]          primitive_id,
  input  logic [4:0]           node_index,
  input  logic signed [31:0]   coord_x,
  input  logic signed [31:0]   coord_y,
  input  logic signed [31:0]   coord_z,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [2:0]           status,
  output logic [15:0]          point_refs,
  output logic [31:0]          mask_after,
  output logic [6:0]           points_held,
  output logic [5:0]           segments_held
);
  localparam int PT_IW = nsrt_pkg::PT_IW;
  localparam int PR_IW = nsrt_pkg::PR_IW;
  localparam int SG_IW = nsrt_pkg::SG_IW;
  localparam int NPT   = nsrt_pkg::POINT_SLOTS;
  localparam int NPR   = nsrt_pkg::PRIM_SLOTS;
  localparam int NSG   = nsrt_pkg::SEG_SLOTS;

  // captured word
  logic        op_r;
  logic [15:0] seg_r, prim_r;
  logic [4:0]  bit_r;
  logic [31:0] x_r, y_r, z_r;

  logic [NPT-1:0] pt_valid;
  logic [31:0]    pt_x [NPT];
  logic [31:0]    pt_y [NPT];
  logic [31:0]    pt_z [NPT];
  logic [NPR-1:0] prim_valid;
  logic [15:0]    prim_key [NPR];
  logic [NSG-1:0] seg_valid;
  logic [15:0]    seg_key [NSG];

  logic [15:0] cnt_mem [NPT];
  logic [31:0] bits_mem [NPR];

  logic [NPT-1:0] pt_match;
  logic [NPR-1:0] prim_match;
  logic [NSG-1:0] seg_match;

  logic             pt_mh, pt_fh, pr_mh, pr_fh, sg_mh, sg_fh;
  logic [PT_IW-1:0] pt_mi, pt_fi;
  logic [PR_IW-1:0] pr_mi, pr_fi;
  logic [SG_IW-1:0] sg_mi, sg_fi;

  logic             pt_hit, pt_ok, pr_hit, pr_ok, sg_hit, sg_ok;
  logic [PT_IW-1:0] pt_idx;
  logic [PR_IW-1:0] pr_idx;
  logic [SG_IW-1:0] sg_idx;
  logic [15:0]      cnt_rd;
  logic [31:0]      bits_rd;

  logic [6:0]  pt_cnt, pt_cnt_n;
  logic [5:0]  sg_cnt, sg_cnt_n;

  logic [31:0] mask_cur, mask_n, bit_sel;
  logic [15:0] refs_cur, refs_n, cnt_wdata;
  logic [2:0]  status_n;
  logic        marked, full, wr_bits, wr_cnt, new_seg, new_prim, new_pt, free_pt;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= opcode;
      seg_r  <= segment_id;
      prim_r <= primitive_id;
      bit_r  <= node_index;
      x_r    <= coord_x;
      y_r    <= coord_y;
      z_r    <= coord_z;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.match) begin
      for (int i = 0; i < NPT; i++)
        pt_match[i] <= pt_valid[i] && pt_x[i] == x_r && pt_y[i] == y_r && pt_z[i] == z_r;
      for (int i = 0; i < NPR; i++)
        prim_match[i] <= prim_valid[i] && prim_key[i] == prim_r;
      for (int i = 0; i < NSG; i++)
        seg_match[i] <= seg_valid[i] && seg_key[i] == seg_r;
    end
  end

  // lowest index wins
  always_comb begin
    pt_mh = 1'b0; pt_mi = '0; pt_fh = 1'b0; pt_fi = '0;
    for (int i = NPT - 1; i >= 0; i--) begin
      if (pt_match[i]) begin pt_mh = 1'b1; pt_mi = PT_IW'(i); end
      if (!pt_valid[i]) begin pt_fh = 1'b1; pt_fi = PT_IW'(i); end
    end
  end

  always_comb begin
    pr_mh = 1'b0; pr_mi = '0; pr_fh = 1'b0; pr_fi = '0;
    for (int i = NPR - 1; i >= 0; i--) begin
      if (prim_match[i]) begin pr_mh = 1'b1; pr_mi = PR_IW'(i); end
      if (!prim_valid[i]) begin pr_fh = 1'b1; pr_fi = PR_IW'(i); end
    end
  end

  always_comb begin
    sg_mh = 1'b0; sg_mi = '0; sg_fh = 1'b0; sg_fi = '0;
    for (int i = NSG - 1; i >= 0; i--) begin
      if (seg_match[i]) begin sg_mh = 1'b1; sg_mi = SG_IW'(i); end
      if (!seg_valid[i]) begin sg_fh = 1'b1; sg_fi = SG_IW'(i); end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seek) begin
      pt_hit  <= pt_mh;
      pt_ok   <= pt_mh || pt_fh;
      pt_idx  <= pt_mh ? pt_mi : pt_fi;
      pr_hit  <= pr_mh;
      pr_ok   <= pr_mh || pr_fh;
      pr_idx  <= pr_mh ? pr_mi : pr_fi;
      sg_hit  <= sg_mh;
      sg_ok   <= sg_mh || sg_fh;
      sg_idx  <= sg_mh ? sg_mi : sg_fi;
      cnt_rd  <= cnt_mem[pt_mh ? pt_mi : pt_fi];
      bits_rd <= bits_mem[pr_mh ? pr_mi : pr_fi];
    end
  end

  always_comb begin
    mask_cur  = pr_hit ? bits_rd : 32'd0;
    refs_cur  = pt_hit ? cnt_rd : 16'd0;
    bit_sel   = 32'd1 << bit_r;
    marked    = (mask_cur & bit_sel) != 32'd0;
    full      = !sg_ok || !pr_ok || !pt_ok;
    status_n  = nsrt_pkg::ST_NONE;
    refs_n    = refs_cur;
    mask_n    = mask_cur;
    wr_bits   = 1'b0;
    wr_cnt    = 1'b0;
    cnt_wdata = cnt_rd;
    new_seg   = 1'b0;
    new_prim  = 1'b0;
    new_pt    = 1'b0;
    free_pt   = 1'b0;
    pt_cnt_n  = pt_cnt;
    sg_cnt_n  = sg_cnt;
    if (op_r == nsrt_pkg::OP_CLEAR) begin
      refs_n   = 16'd0;
      mask_n   = 32'd0;
      pt_cnt_n = 7'd0;
      sg_cnt_n = 6'd0;
    end else if (add_mode) begin
      if (marked) begin
        status_n = nsrt_pkg::ST_MARKED;
      end else if (full) begin
        status_n = nsrt_pkg::ST_FULL;
      end else begin
        new_seg  = !sg_hit;
        new_prim = !pr_hit;
        wr_bits  = 1'b1;
        mask_n   = mask_cur | bit_sel;
        wr_cnt   = 1'b1;
        if (pt_hit) begin
          cnt_wdata = (cnt_rd == 16'hFFFF) ? cnt_rd : cnt_rd + 16'd1;
          status_n  = nsrt_pkg::ST_RAISED;
        end else begin
          cnt_wdata = 16'd1;
          new_pt    = 1'b1;
          status_n  = nsrt_pkg::ST_NEW;
        end
        refs_n = cnt_wdata;
        if (new_pt) pt_cnt_n = pt_cnt + 7'd1;
        if (new_seg) sg_cnt_n = sg_cnt + 6'd1;
      end
    end else if (marked && pr_hit) begin
      wr_bits = 1'b1;
      mask_n  = mask_cur & ~bit_sel;
      if (pt_hit) begin
        wr_cnt    = 1'b1;
        cnt_wdata = cnt_rd - {15'd0, cnt_rd != 16'd0};
        refs_n    = cnt_wdata;
        if (cnt_wdata == 16'd0) begin
          free_pt  = 1'b1;
          pt_cnt_n = pt_cnt - 7'd1;
          status_n = nsrt_pkg::ST_FREED;
        end else begin
          status_n = nsrt_pkg::ST_LOWERED;
        end
      end else begin
        refs_n = 16'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pt_valid   <= '0;
      prim_valid <= '0;
      seg_valid  <= '0;
      pt_cnt     <= '0;
      sg_cnt     <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.exec) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cmd.exec) begin
        pt_cnt    <= pt_cnt_n;
        sg_cnt    <= sg_cnt_n;
        if (op_r == nsrt_pkg::OP_CLEAR) begin
          pt_valid   <= '0;
          prim_valid <= '0;
          seg_valid  <= '0;
        end else begin
          if (new_seg) seg_valid[sg_idx] <= 1'b1;
          if (new_prim) prim_valid[pr_idx] <= 1'b1;
          if (new_pt) pt_valid[pt_idx] <= 1'b1;
          if (free_pt) pt_valid[pt_idx] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && op_r == nsrt_pkg::OP_UPDATE) begin
      if (new_seg) seg_key[sg_idx] <= seg_r;
      if (new_prim) prim_key[pr_idx] <= prim_r;
      if (new_pt) begin
        pt_x[pt_idx] <= x_r;
        pt_y[pt_idx] <= y_r;
        pt_z[pt_idx] <= z_r;
      end
      if (wr_bits) bits_mem[pr_idx] <= mask_n;
      if (wr_cnt) cnt_mem[pt_idx] <= cnt_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status        <= status_n;
      point_refs    <= refs_n;
      mask_after    <= mask_n;
      points_held   <= pt_cnt_n;
      segments_held <= sg_cnt_n;
    end
  end

  assign stat.out_busy = out_valid && !out_ready;
endmodule

// ----- src/node_selection_refcount_table_core.sv -----
// Node selection table: one result word per input word, in order. Each word passes
// four steps (capture, parallel key compare, slot pick with table read, update),
// set by the control sequence and the single read port of the count and mask
// memories; a new word is taken once the previous one has entered the output
// register. Reset leaves all tables empty with no clearing pass. Configuration (add_mode
// at address 0) is written by the user while the block is idle; the block relies on it.
module node_selection_refcount_table_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               opcode,
  input  logic [15:0]        segment_id,
  input  logic [15:0]        primitive_id,
  input  logic [4:0]         node_index,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic signed [31:0] coord_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic [15:0]        point_refs,
  output logic [31:0]        mask_after,
  output logic [6:0]         points_held,
  output logic [5:0]         segments_held
);
  logic                 add_mode;
  nsrt_pkg::nsrt_cmd_t  cmd;
  nsrt_pkg::nsrt_stat_t stat;

  assign pready = 1'b1;
  assign prdata = (paddr == nsrt_pkg::ADDR_ADD_MODE) ? {31'd0, add_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) add_mode <= 1'b0;
    else if (psel && penable && pwrite && pready && paddr == nsrt_pkg::ADDR_ADD_MODE)
      add_mode <= pwdata[0];
  end

  nsrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  nsrt_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .add_mode      (add_mode),
    .opcode        (opcode),
    .segment_id    (segment_id),
    .primitive_id  (primitive_id),
    .node_index    (node_index),
    .coord_x       (coord_x),
    .coord_y       (coord_y),
    .coord_z       (coord_z),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .status        (status),
    .point_refs    (point_refs),
    .mask_after    (mask_after),
    .points_held   (points_held),
    .segments_held (segments_held)
  );
endmodule

// ----- src/nsrt_checker.sv -----
`include "node_selection_refcount_table_core_assert.svh"
module nsrt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [15:0] point_refs
);
  `NSRT_CHECK(out_hold, out_valid && !out_ready |=> out_valid)
  `NSRT_CHECK(busy_after_accept, in_valid && in_ready |=> !in_ready)
  `NSRT_CHECK(new_point_one, out_valid && status == nsrt_pkg::ST_NEW |-> point_refs == 16'd1)
  `NSRT_CHECK_ALWAYS(freed_zero,
    out_valid && status == nsrt_pkg::ST_FREED |-> point_refs == 16'd0)
endmodule

bind node_selection_refcount_table_core nsrt_checker u_nsrt_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .status     (status),
  .point_refs (point_refs)
);
